[rtl/svpwm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, fixed-point constants and CORDIC tables for the space vector
// PWM duty block.
// ----------------------------------------------------------------------------
package svpwm_pkg;

	localparam int unsigned FRAC_BITS_DEF     = 14;
	localparam int unsigned CORDIC_STAGES_DEF = 16;

	// angle width: Q.30 radians, covers 0..2*pi with sign
	localparam int AW    = 34;
	localparam int VFRAC = 24;

	localparam longint Q_THIRD     = 64'd357913941;
	localparam longint Q_INV_SQRT3 = 64'd619925131;
	localparam longint Q_SQRT3     = 64'd1859775393;
	localparam longint Q_HALF_PI   = 64'd1686629713;
	localparam longint Q_PI_3      = 64'd1124419809;
	localparam longint Q_TWO_PI    = 64'd6746518852;

	localparam logic [15:0] PERIOD_RESET   = 16'd5000;
	localparam logic        REG_PWM_PERIOD = 1'b0;

	typedef logic signed [AW-1:0] angle_t;

	// atan(2^-i) in Q.30, truncated
	function automatic angle_t atan_q30(input int i);
		angle_t r;
		case (i)
			0:       r = AW'(64'h3243F6A8);
			1:       r = AW'(64'h1DAC6705);
			2:       r = AW'(64'h0FADBAFC);
			3:       r = AW'(64'h07F56EA6);
			4:       r = AW'(64'h03FEAB76);
			5:       r = AW'(64'h01FFD55B);
			6:       r = AW'(64'h00FFFAAA);
			7:       r = AW'(64'h007FFF55);
			8:       r = AW'(64'h003FFFEA);
			9:       r = AW'(64'h001FFFFD);
			10:      r = AW'(64'h000FFFFF);
			11:      r = AW'(64'h0007FFFF);
			12:      r = AW'(64'h0003FFFF);
			13:      r = AW'(64'h0001FFFF);
			14:      r = AW'(64'h0000FFFF);
			15:      r = AW'(64'h00007FFF);
			16:      r = AW'(64'h00003FFF);
			17:      r = AW'(64'h00001FFF);
			18:      r = AW'(64'h00000FFF);
			19:      r = AW'(64'h000007FF);
			20:      r = AW'(64'h000003FF);
			21:      r = AW'(64'h000001FF);
			22:      r = AW'(64'h000000FF);
			23:      r = AW'(64'h0000007F);
			default: r = '0;
		endcase
		return r;
	endfunction

	// combined gain of vectoring plus one rotation, Q.30
	function automatic longint unsigned gain_sq_q30(input int n);
		longint unsigned p;
		p = 64'd1 << 30;
		for (int i = 0; i < n; i++) begin
			p = p + (p >> (2 * i));
		end
		return p;
	endfunction

endpackage
`default_nettype wire

[rtl/space_vector_pwm_duty.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Two-level three-phase space vector PWM: phase commands in, compare values,
// sector and overmodulation flag out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one request carries the three Q2.14 phase commands.
//   Output stream m_*: one result per request, in order: three compare
//   values, the sector (1..6) and the overmodulation flag.
//   APB port: register 0 at byte address 0 holds the PWM period (reset 5000);
//   write it only while no request is in flight.
//   The pipeline runs through three input stages, the vectoring chain, two
//   angle stages, the rotation chains, gain multiply, half zero time, phase
//   sums, period multiply and the output register.
//   Throughput is one request per cycle while the receiver is not stalling; every chain cell advances together.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; bubbles do not close up while held.
//   Reset empties the pipeline and restores the period.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty #(
	parameter int FRAC_BITS     = svpwm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = svpwm_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // phase_a_cmd, phase_b_cmd, phase_c_cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // compare_a, compare_b, compare_c,
	                                    // sector_number, overmodulated, pad
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import svpwm_pkg::*;

	localparam int N  = CORDIC_STAGES;
	localparam int CW = 44 - FRAC_BITS;
	localparam int SH = FRAC_BITS + 6;
	localparam int TW = CW + 3;
	localparam int PW = TW + 1;
	localparam int MW = PW + 17;
	localparam longint unsigned G_VAL = (Q_SQRT3 << 30) / gain_sq_q30(N);

	localparam logic signed [30:0] K_THIRD   = 31'(Q_THIRD);
	localparam logic signed [30:0] K_ISQRT3  = 31'(Q_INV_SQRT3);
	localparam logic signed [31:0] K_GAIN    = 32'(G_VAL);
	localparam angle_t             HALF_PI_A = AW'(Q_HALF_PI);
	localparam angle_t             PI3_A     = AW'(Q_PI_3);
	localparam angle_t             TWO_PI_A  = AW'(Q_TWO_PI);
	localparam logic signed [TW-1:0] ONE_T   = TW'(64'd1 << VFRAC);
	localparam logic signed [PW-1:0] BIAS_P  = PW'(64'd1 << (VFRAC - 1));

	logic        en;
	logic [15:0] period_q;

	svpwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.period_q (period_q)
	);

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- stage 1: phase sums
	logic                vld_s1;
	logic signed [17:0]  sab_s1;
	logic signed [16:0]  sbc_s1;
	logic signed [15:0]  cmd_a, cmd_b, cmd_c;

	assign cmd_a = signed'(s_tdata[15:0]);
	assign cmd_b = signed'(s_tdata[31:16]);
	assign cmd_c = signed'(s_tdata[47:32]);

	// ---- stage 2: alpha / beta
	logic                 vld_s2;
	logic signed [CW-1:0] alpha_s2, beta_s2;
	logic signed [47:0]   prod_al, prod_be;

	assign prod_al = 48'(sab_s1) * 48'(K_THIRD);
	assign prod_be = 48'(sbc_s1) * 48'(K_ISQRT3);

	// ---- stage 3: quadrant fold into the right half plane
	logic                 vld_s3;
	logic signed [CW-1:0] vx_s3, vy_s3;
	angle_t               vz_s3;
	logic                 zero_s3;

	// ---- vectoring chain
	logic [N:0]           vvld_q;
	logic [N:0]           vzero_q;
	logic signed [CW-1:0] vx [0:N];
	logic signed [CW-1:0] vy [0:N];
	angle_t               vz [0:N];

	assign vvld_q[0]  = vld_s3;
	assign vzero_q[0] = zero_s3;
	assign vx[0] = vx_s3;
	assign vy[0] = vy_s3;
	assign vz[0] = vz_s3;

	for (genvar i = 0; i < N; i++) begin : g_vec
		svpwm_cordic_cell #(.CW(CW), .STAGE(i), .VECTOR(1'b1)) u_cell (
			.clk  (clk),
			.en   (en),
			.x_in (vx[i]),
			.y_in (vy[i]),
			.z_in (vz[i]),
			.x_q  (vx[i+1]),
			.y_q  (vy[i+1]),
			.z_q  (vz[i+1])
		);
	end

	// ---- stage 4: unwrap angle
	logic                 vld_s4;
	angle_t               theta_s4;
	logic signed [CW-1:0] mag_s4;

	// ---- stage 5: sector and angle inside sector
	logic                 vld_s5;
	logic [2:0]           sec_s5;
	angle_t               d_s5, e_s5;
	logic signed [CW-1:0] mag_s5;
	logic [4:0]           ge;
	logic [2:0]           cnt;
	angle_t               base;

	always_comb begin
		for (int k = 1; k <= 5; k++) begin
			ge[k-1] = theta_s4 >= AW'(longint'(k) * Q_PI_3);
		end
		cnt = 3'd0;
		for (int k = 0; k < 5; k++) begin
			cnt = cnt + 3'(ge[k]);
		end
		case (cnt)
			3'd0:    base = '0;
			3'd1:    base = AW'(Q_PI_3);
			3'd2:    base = AW'(2 * Q_PI_3);
			3'd3:    base = AW'(3 * Q_PI_3);
			3'd4:    base = AW'(4 * Q_PI_3);
			default: base = AW'(5 * Q_PI_3);
		endcase
	end

	// ---- rotation chains: sin(d) and sin(pi/3 - d)
	logic [N:0]           rvld_q;
	logic [2:0]           rsec_q [0:N];
	logic signed [CW-1:0] ax [0:N];
	logic signed [CW-1:0] ay [0:N];
	angle_t               az [0:N];
	logic signed [CW-1:0] bx [0:N];
	logic signed [CW-1:0] by [0:N];
	angle_t               bz [0:N];

	assign rvld_q[0] = vld_s5;
	assign rsec_q[0] = sec_s5;
	assign ax[0] = mag_s5;
	assign ay[0] = '0;
	assign az[0] = d_s5;
	assign bx[0] = mag_s5;
	assign by[0] = '0;
	assign bz[0] = e_s5;

	for (genvar i = 0; i < N; i++) begin : g_rot
		svpwm_cordic_cell #(.CW(CW), .STAGE(i), .VECTOR(1'b0)) u_cell_a (
			.clk  (clk),
			.en   (en),
			.x_in (ax[i]),
			.y_in (ay[i]),
			.z_in (az[i]),
			.x_q  (ax[i+1]),
			.y_q  (ay[i+1]),
			.z_q  (az[i+1])
		);
		svpwm_cordic_cell #(.CW(CW), .STAGE(i), .VECTOR(1'b0)) u_cell_b (
			.clk  (clk),
			.en   (en),
			.x_in (bx[i]),
			.y_in (by[i]),
			.z_in (bz[i]),
			.x_q  (bx[i+1]),
			.y_q  (by[i+1]),
			.z_q  (bz[i+1])
		);
	end

	// ---- stage 6: gain correction gives t2, t1
	logic                   vld_s6;
	logic [2:0]             sec_s6;
	logic signed [TW-1:0]   t1_s6, t2_s6;
	logic signed [CW+31:0]  prod_t2, prod_t1;

	assign prod_t2 = (CW+32)'(ay[N]) * (CW+32)'(K_GAIN);
	assign prod_t1 = (CW+32)'(by[N]) * (CW+32)'(K_GAIN);

	// ---- stage 7: half zero time
	logic                 vld_s7;
	logic [2:0]           sec_s7;
	logic signed [TW-1:0] t1_s7, t2_s7, h_s7;
	logic signed [TW-1:0] t0;

	assign t0 = ONE_T - t1_s6 - t2_s6;

	// ---- stage 8: per-phase on-times, shifted by +0.5
	logic                 vld_s8;
	logic [2:0]           sec_s8;
	logic signed [PW-1:0] pa_s8, pb_s8, pc_s8;
	logic signed [PW-1:0] p12, p1, p2, ph;

	assign p12 = PW'(t1_s7) + PW'(t2_s7) + PW'(h_s7) + BIAS_P;
	assign p1  = PW'(t1_s7) + PW'(h_s7) + BIAS_P;
	assign p2  = PW'(t2_s7) + PW'(h_s7) + BIAS_P;
	assign ph  = PW'(h_s7) + BIAS_P;

	// ---- stage 9: scale by period
	logic                 vld_s9;
	logic [2:0]           sec_s9;
	logic signed [MW-1:0] ma_s9, mb_s9, mc_s9;
	logic signed [MW-1:0] per_s;

	assign per_s = MW'(signed'({1'b0, period_q}));

	// ---- output register
	logic        out_vld_q;
	logic [15:0] cmp_a_q, cmp_b_q, cmp_c_q;
	logic [2:0]  sec_q;
	logic        ovm_q;
	logic [16:0] sat_a, sat_b, sat_c;

	function automatic logic [16:0] sat_cmp(input logic signed [MW-1:0] m,
	                                        input logic [15:0] per);
		logic signed [MW-1:0] v;
		logic signed [MW-1:0] lim;
		v   = m >>> (VFRAC + 1);
		lim = MW'(signed'({1'b0, per}));
		if (v < 0) begin
			return {1'b1, 16'd0};
		end else if (v > lim) begin
			return {1'b1, per};
		end
		return {1'b0, v[15:0]};
	endfunction

	assign sat_a = sat_cmp(ma_s9, period_q);
	assign sat_b = sat_cmp(mb_s9, period_q);
	assign sat_c = sat_cmp(mc_s9, period_q);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			out_vld_q <= 1'b0;
			vvld_q[N:1] <= '0;
			rvld_q[N:1] <= '0;
		end else if (en) begin
			vld_s1    <= s_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vvld_q[N:1] <= vvld_q[N-1:0];
			vld_s4    <= vvld_q[N];
			vld_s5    <= vld_s4;
			rvld_q[N:1] <= rvld_q[N-1:0];
			vld_s6    <= rvld_q[N];
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			out_vld_q <= vld_s9;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			sab_s1 <= (18'(cmd_a) <<< 1) - 18'(cmd_b) - 18'(cmd_c);
			sbc_s1 <= 17'(cmd_b) - 17'(cmd_c);

			alpha_s2 <= CW'(prod_al >>> SH);
			beta_s2  <= CW'(prod_be >>> SH);

			zero_s3 <= (alpha_s2 == '0) && (beta_s2 == '0);
			if (alpha_s2 < 0) begin
				if (beta_s2 >= 0) begin
					vx_s3 <= beta_s2;
					vy_s3 <= -alpha_s2;
					vz_s3 <= HALF_PI_A;
				end else begin
					vx_s3 <= -beta_s2;
					vy_s3 <= alpha_s2;
					vz_s3 <= -HALF_PI_A;
				end
			end else begin
				vx_s3 <= alpha_s2;
				vy_s3 <= beta_s2;
				vz_s3 <= '0;
			end

			vzero_q[N:1] <= vzero_q[N-1:0];

			// zero vector: angle 0; magnitude is already 0
			if (vzero_q[N]) begin
				theta_s4 <= '0;
			end else if (vz[N] < 0) begin
				theta_s4 <= vz[N] + TWO_PI_A;
			end else begin
				theta_s4 <= vz[N];
			end
			mag_s4 <= vx[N];

			sec_s5 <= cnt + 3'd1;
			d_s5   <= theta_s4 - base;
			e_s5   <= base + PI3_A - theta_s4;
			mag_s5 <= mag_s4;

			for (int i = 1; i <= N; i++) begin
				rsec_q[i] <= rsec_q[i-1];
			end

			sec_s6 <= rsec_q[N];
			t2_s6  <= TW'(prod_t2 >>> 30);
			t1_s6  <= TW'(prod_t1 >>> 30);

			sec_s7 <= sec_s6;
			t1_s7  <= t1_s6;
			t2_s7  <= t2_s6;
			h_s7   <= t0 >>> 1;

			sec_s8 <= sec_s7;
			case (sec_s7)
				3'd1: begin
					pa_s8 <= p12; pb_s8 <= p2;  pc_s8 <= ph;
				end
				3'd2: begin
					pa_s8 <= p1;  pb_s8 <= p12; pc_s8 <= ph;
				end
				3'd3: begin
					pa_s8 <= ph;  pb_s8 <= p12; pc_s8 <= p2;
				end
				3'd4: begin
					pa_s8 <= ph;  pb_s8 <= p1;  pc_s8 <= p12;
				end
				3'd5: begin
					pa_s8 <= p2;  pb_s8 <= ph;  pc_s8 <= p12;
				end
				default: begin
					pa_s8 <= p12; pb_s8 <= ph;  pc_s8 <= p1;
				end
			endcase

			sec_s9 <= sec_s8;
			ma_s9  <= MW'(pa_s8) * per_s;
			mb_s9  <= MW'(pb_s8) * per_s;
			mc_s9  <= MW'(pc_s8) * per_s;

			sec_q   <= sec_s9;
			cmp_a_q <= sat_a[15:0];
			cmp_b_q <= sat_b[15:0];
			cmp_c_q <= sat_c[15:0];
			ovm_q   <= sat_a[16] | sat_b[16] | sat_c[16];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, ovm_q, sec_q, cmp_c_q, cmp_b_q, cmp_a_q};

`ifndef ASSERT_OFF
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (sec_q != 3'd0 && sec_q != 3'd7))
		else $error("sector out of range");

	a_cmp_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cmp_a_q <= period_q && cmp_b_q <= period_q && cmp_c_q <= period_q))
		else $error("compare value above period");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vvld_q) && $stable(rvld_q) && $stable(out_vld_q)))
		else $error("pipeline moved during stall");

	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && period_q == 16'd0) |->
		(cmp_a_q == 16'd0 && cmp_b_q == 16'd0 && cmp_c_q == 16'd0))
		else $error("nonzero compare with zero period");
`endif

endmodule
`default_nettype wire

[rtl/svpwm_cordic_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_cordic_cell
// One CORDIC micro-rotation with its output register; vectoring or rotation.
// ----------------------------------------------------------------------------
module svpwm_cordic_cell #(
	parameter int CW     = 30,
	parameter int STAGE  = 0,
	parameter bit VECTOR = 1'b1
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [CW-1:0]   x_in,
	input  wire logic signed [CW-1:0]   y_in,
	input  wire svpwm_pkg::angle_t      z_in,
	output logic signed [CW-1:0]        x_q,
	output logic signed [CW-1:0]        y_q,
	output svpwm_pkg::angle_t           z_q
);
	import svpwm_pkg::*;

	localparam angle_t ATAN = atan_q30(STAGE);

	logic                 ccw;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	// vectoring drives y toward zero, rotation drives z toward zero
	assign ccw = VECTOR ? y_in[CW-1] : !z_in[AW-1];
	assign dx  = y_in >>> STAGE;
	assign dy  = x_in >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ATAN;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/svpwm_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_cfg
// APB register file holding the PWM period.
// ----------------------------------------------------------------------------
module svpwm_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [15:0]      period_q
);
	import svpwm_pkg::*;

	logic hit;

	// register index sits in paddr[2]; byte offset bits are ignored
	assign hit    = (paddr[2] == REG_PWM_PERIOD) && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00);
	assign pready = 1'b1;
	assign prdata = hit ? {16'd0, period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			period_q <= pwdata[15:0];
		end
	end

endmodule
`default_nettype wire
